// ----- hw/rtl/buddy_page_allocator_core_defines.svh -----
// Assertion macros for the buddy page allocator core.
// Used by the top level only; no other dependencies.
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define BPA_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define BPA_ASSERT(lbl, clk, rst_n, prop)
`define BPA_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- hw/rtl/bpa_pkg.sv -----
// Shared types, constants and helper functions of the buddy page allocator.
// No dependencies; imported by every module of the block.
package bpa_pkg;

    localparam int ORDER_COUNT = 11;
    localparam int PAGE_COUNT  = 65536;
    localparam int PAGE_W      = 16;
    localparam int LINK_W      = 17;
    localparam int ORD_W       = 4;
    localparam int PAGE_SHIFT  = 12;
    localparam int SIZE_W      = 32;
    localparam int PG_NUM_W    = SIZE_W - PAGE_SHIFT;
    localparam int AORD_W      = 5;

    localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(PAGE_COUNT);
    localparam logic [ORD_W-1:0]  TOP_ORD = ORD_W'(ORDER_COUNT - 1);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_ADD   = 2'd2
    } t_op;

    typedef struct packed {
        logic              alloc;
        logic [ORD_W-1:0]  order;
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
    } t_frame;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [PAGE_W-1:0] addr;
        t_frame            wdata;
    } t_mem_req;

    typedef struct packed {
        logic              we;
        logic [ORD_W-1:0]  ord;
        logic [LINK_W-1:0] val;
    } t_head_req;

    function automatic logic link_ok(input logic [LINK_W-1:0] l);
        return l < LINK_W'(PAGE_COUNT);
    endfunction

    // Smallest order whose block covers size bytes (bit length of pages - 1).
    function automatic logic [AORD_W-1:0] alloc_order(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0]   m1;
        logic [PG_NUM_W-1:0] pg;
        logic [AORD_W-1:0]   bl;
        m1 = size - SIZE_W'(1);
        pg = m1[SIZE_W-1:PAGE_SHIFT];
        bl = '0;
        for (int i = 0; i < PG_NUM_W; i++) begin
            if (pg[i]) bl = AORD_W'(i + 1);
        end
        if (size == '0) bl = '0;
        return bl;
    endfunction

    // Largest aligned block at first that still fits in rem pages.
    function automatic logic [ORD_W-1:0] range_order(input logic [LINK_W-1:0] first,
                                                     input logic [LINK_W-1:0] rem);
        logic [ORD_W-1:0] tz;
        logic [ORD_W:0]   fl;
        tz = TOP_ORD;
        for (int i = ORDER_COUNT - 2; i >= 0; i--) begin
            if (first[i]) tz = ORD_W'(i);
        end
        fl = '0;
        for (int i = 0; i < LINK_W; i++) begin
            if (rem[i]) fl = (ORD_W+1)'(i);
        end
        return (fl < {1'b0, tz}) ? fl[ORD_W-1:0] : tz;
    endfunction

endpackage

// ----- hw/rtl/bpa_frame_mem.sv -----
// Per-page frame table: one single-port synchronous RAM with registered read data.
// Depends on bpa_pkg.
module bpa_frame_mem (
    input  logic              i_clk,
    input  bpa_pkg::t_mem_req i_req,
    output bpa_pkg::t_frame   o_rdata
);
    import bpa_pkg::*;

    t_frame r_mem [PAGE_COUNT];
    t_frame r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                r_mem[i_req.addr] <= i_req.wdata;
            end else begin
                r_rdata <= r_mem[i_req.addr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/bpa_head_table.sv -----
// Free list heads, one per order, with the search for a non-empty list.
// Depends on bpa_pkg.
module bpa_head_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bpa_pkg::t_head_req         i_req,
    input  logic [bpa_pkg::ORD_W-1:0]  i_rd_ord,
    output logic [bpa_pkg::LINK_W-1:0] o_rd_val,
    input  logic [bpa_pkg::ORD_W-1:0]  i_min_ord,
    output logic                       o_found,
    output logic [bpa_pkg::ORD_W-1:0]  o_found_ord
);
    import bpa_pkg::*;

    logic [LINK_W-1:0] r_head [ORDER_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ORDER_COUNT; i++) r_head[i] <= NO_LINK;
        end else if (i_req.we) begin
            r_head[i_req.ord] <= i_req.val;
        end
    end

    assign o_rd_val = r_head[i_rd_ord];

    // lowest non-empty order at or above the request
    always_comb begin
        o_found     = 1'b0;
        o_found_ord = '0;
        for (int k = ORDER_COUNT - 1; k >= 0; k--) begin
            if (ORD_W'(k) >= i_min_ord && link_ok(r_head[k])) begin
                o_found     = 1'b1;
                o_found_ord = ORD_W'(k);
            end
        end
    end
endmodule

// ----- hw/rtl/buddy_page_allocator_core.sv -----
// Buddy page allocator core: top level sequencer, config register, result register.
// Depends on bpa_pkg, bpa_frame_mem, bpa_head_table and the defines header.
//
// Usage:
//   Request channel: i_in_valid / o_in_stall with i_operation (0 allocate,
//   1 free, 2 add range), i_size_bytes, i_free_page, i_range_first_page and
//   i_range_page_count. A transfer takes place when valid is high and stall low.
//   Result channel: o_out_valid / i_out_stall with o_status, o_block_page,
//   o_block_order; exactly one result per request, in request order.
//   Config: i_cfg_we writes i_cfg_wdata into managed_pages (write it while idle).
//   Timing: one request at a time. All frame table accesses go through one
//   single-port RAM, so the time from transfer to result, the result register
//   load included, follows the reads and writes a request needs: for add range
//   it grows with the blocks pushed, for allocate with the split levels and for
//   free with the merge levels. The core returns to idle in the same cycle as
//   the result register loads.
//   A finished result waits in the output register while the receiver stalls;
//   the next request is accepted meanwhile and stalls only at its own end.
//   Reset: after i_rst_n is released a clearing pass marks all 65536 frames
//   allocated at order 0, one per cycle; o_in_stall stays high until the pass
//   ends. All free lists start empty.
`include "buddy_page_allocator_core_defines.svh"
module buddy_page_allocator_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_operation,
    input  logic [31:0]                i_size_bytes,
    input  logic [15:0]                i_free_page,
    input  logic [15:0]                i_range_first_page,
    input  logic [16:0]                i_range_page_count,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_status,
    output logic [15:0]                o_block_page,
    output logic [3:0]                 o_block_order,
    input  logic                       i_cfg_we,
    input  logic [16:0]                i_cfg_wdata
);
    import bpa_pkg::*;

    typedef enum logic [25:0] {
        S_CLEAR   = 26'd1 << 0,
        S_IDLE    = 26'd1 << 1,
        S_A_START = 26'd1 << 2,
        S_POP_R   = 26'd1 << 3,
        S_POP_W   = 26'd1 << 4,
        S_POP_NR  = 26'd1 << 5,
        S_POP_NW  = 26'd1 << 6,
        S_SPLIT   = 26'd1 << 7,
        S_ASET_R  = 26'd1 << 8,
        S_ASET_W  = 26'd1 << 9,
        S_F_START = 26'd1 << 10,
        S_F_W0    = 26'd1 << 11,
        S_F_CHK   = 26'd1 << 12,
        S_F_BUD   = 26'd1 << 13,
        S_U_P     = 26'd1 << 14,
        S_U_PW    = 26'd1 << 15,
        S_U_N     = 26'd1 << 16,
        S_U_NW    = 26'd1 << 17,
        S_F_MRG   = 26'd1 << 18,
        S_F_MW    = 26'd1 << 19,
        S_R_START = 26'd1 << 20,
        S_R_LOOP  = 26'd1 << 21,
        S_PUSH_W  = 26'd1 << 22,
        S_PUSH_R  = 26'd1 << 23,
        S_PUSH_M  = 26'd1 << 24,
        S_FIN     = 26'd1 << 25
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    logic [PAGE_W-1:0] r_clr, n_clr;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [LINK_W-1:0] r_idx, n_idx, r_end, n_end, r_count, n_count;
    logic [LINK_W-1:0] r_p, n_p, r_n, n_n, r_h, n_h;
    logic [ORD_W-1:0]  r_ord, n_ord, r_tgt, n_tgt, r_j, n_j, r_push_ord, n_push_ord;
    logic [PAGE_W-1:0] r_buddy, n_buddy, r_push_idx, n_push_idx;
    logic              r_res_status, n_res_status;
    logic [PAGE_W-1:0] r_res_page, n_res_page;
    logic [ORD_W-1:0]  r_res_order, n_res_order;
    logic              r_out_valid, n_out_valid;
    logic              r_out_status, n_out_status;
    logic [PAGE_W-1:0] r_out_page, n_out_page;
    logic [ORD_W-1:0]  r_out_order, n_out_order;
    logic [LINK_W-1:0] r_managed;

    t_mem_req          mem_req;
    t_frame            mem_rdata, wd;
    t_head_req         head_req;
    logic [ORD_W-1:0]  head_rd_ord, head_min_ord, found_ord;
    logic [LINK_W-1:0] head_rd_val, limit, half, rng_sum_end;
    logic              found;
    logic [AORD_W-1:0] aord;
    logic [ORD_W-1:0]  jm1, rord;
    logic [PAGE_W-1:0] buddy, midx;
    logic [LINK_W:0]   rng_sum;

    bpa_frame_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    bpa_head_table u_heads (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (head_req),
        .i_rd_ord    (head_rd_ord),
        .o_rd_val    (head_rd_val),
        .i_min_ord   (head_min_ord),
        .o_found     (found),
        .o_found_ord (found_ord)
    );

    // merge limit: the smaller of the register and the table size
    assign limit = (r_managed < LINK_W'(PAGE_COUNT)) ? r_managed : LINK_W'(PAGE_COUNT);

    assign aord         = alloc_order(r_size);
    assign head_min_ord = aord[ORD_W-1:0];
    assign jm1          = r_j - ORD_W'(1);
    assign half         = r_idx + (LINK_W'(1) << jm1);
    assign buddy        = r_idx[PAGE_W-1:0] ^ (PAGE_W'(1) << r_ord);
    assign midx         = r_idx[PAGE_W-1:0] & r_buddy;
    assign rng_sum      = {2'b00, r_idx[PAGE_W-1:0]} + {1'b0, r_count};
    assign rng_sum_end  = (rng_sum > (LINK_W+1)'(PAGE_COUNT)) ? NO_LINK
                                                               : rng_sum[LINK_W-1:0];
    assign rord         = range_order(r_idx, r_end - r_idx);

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_clr        = r_clr;
        n_size       = r_size;
        n_idx        = r_idx;
        n_end        = r_end;
        n_count      = r_count;
        n_p          = r_p;
        n_n          = r_n;
        n_h          = r_h;
        n_ord        = r_ord;
        n_tgt        = r_tgt;
        n_j          = r_j;
        n_push_ord   = r_push_ord;
        n_buddy      = r_buddy;
        n_push_idx   = r_push_idx;
        n_res_status = r_res_status;
        n_res_page   = r_res_page;
        n_res_order  = r_res_order;
        n_out_status = r_out_status;
        n_out_page   = r_out_page;
        n_out_order  = r_out_order;
        // drop the result once the receiver takes it
        n_out_valid  = r_out_valid && i_out_stall;
        mem_req      = '0;
        head_req     = '0;
        head_rd_ord  = r_push_ord;
        wd           = mem_rdata;

        unique case (r_state)
            S_CLEAR: begin
                // mark every frame allocated at order zero
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = r_clr;
                mem_req.wdata = '{alloc: 1'b1, order: '0, nxt: '0, prv: '0};
                n_clr         = r_clr + PAGE_W'(1);
                if (r_clr == PAGE_W'(PAGE_COUNT - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_size       = i_size_bytes;
                    n_count      = i_range_page_count;
                    n_res_status = 1'b0;
                    n_res_page   = '0;
                    n_res_order  = '0;
                    case (i_operation)
                        OP_ALLOC: n_state = S_A_START;
                        OP_FREE: begin
                            n_idx   = {1'b0, i_free_page};
                            n_state = S_F_START;
                        end
                        OP_ADD: begin
                            n_idx   = {1'b0, i_range_first_page};
                            n_state = S_R_START;
                        end
                        default: begin
                            n_res_status = 1'b1;
                            n_state      = S_FIN;
                        end
                    endcase
                end
            end
            // ---------------- allocate ----------------
            S_A_START: begin
                if (aord >= AORD_W'(ORDER_COUNT) || !found) begin
                    n_res_status = 1'b1;
                    n_state      = S_FIN;
                end else begin
                    n_tgt   = aord[ORD_W-1:0];
                    n_j     = found_ord;
                    n_state = S_POP_R;
                end
            end
            S_POP_R: begin
                head_rd_ord  = r_j;
                n_idx        = head_rd_val;
                mem_req.en   = 1'b1;
                mem_req.addr = head_rd_val[PAGE_W-1:0];
                n_state      = S_POP_W;
            end
            S_POP_W: begin
                wd.alloc      = 1'b1;
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = r_idx[PAGE_W-1:0];
                mem_req.wdata = wd;
                n_n           = mem_rdata.nxt;
                head_req.we   = 1'b1;
                head_req.ord  = r_j;
                head_req.val  = link_ok(mem_rdata.nxt) ? mem_rdata.nxt : NO_LINK;
                n_state       = link_ok(mem_rdata.nxt) ? S_POP_NR : S_SPLIT;
            end
            S_POP_NR: begin
                mem_req.en   = 1'b1;
                mem_req.addr = r_n[PAGE_W-1:0];
                n_state      = S_POP_NW;
            end
            S_POP_NW: begin
                wd.prv        = NO_LINK;
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = r_n[PAGE_W-1:0];
                mem_req.wdata = wd;
                n_state       = S_SPLIT;
            end
            S_SPLIT: begin
                // hand the upper half down one order per level
                if (r_j > r_tgt) begin
                    n_j = jm1;
                    if (link_ok(half)) begin
                        n_push_idx = half[PAGE_W-1:0];
                        n_push_ord = jm1;
                        n_ret      = S_SPLIT;
                        n_state    = S_PUSH_W;
                    end
                end else begin
                    n_state = S_ASET_R;
                end
            end
            S_ASET_R: begin
                mem_req.en   = 1'b1;
                mem_req.addr = r_idx[PAGE_W-1:0];
                n_state      = S_ASET_W;
            end
            S_ASET_W: begin
                wd.order      = r_tgt;
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = r_idx[PAGE_W-1:0];
                mem_req.wdata = wd;
                n_res_page    = r_idx[PAGE_W-1:0];
                n_res_order   = r_tgt;
                n_state       = S_FIN;
            end
            // ---------------- free ----------------
            S_F_START: begin
                mem_req.en   = 1'b1;
                mem_req.addr = r_idx[PAGE_W-1:0];
                n_state      = S_F_W0;
            end
            S_F_W0: begin
                wd.alloc      = 1'b0;
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = r_idx[PAGE_W-1:0];
                mem_req.wdata = wd;
                n_ord         = mem_rdata.order;
                n_state       = S_F_CHK;
            end
            S_F_CHK: begin
                if (r_ord < TOP_ORD && {1'b0, buddy} < limit) begin
                    n_buddy      = buddy;
                    mem_req.en   = 1'b1;
                    mem_req.addr = buddy;
                    n_state      = S_F_BUD;
                end else begin
                    n_push_idx = r_idx[PAGE_W-1:0];
                    n_push_ord = (r_ord < TOP_ORD) ? r_ord : TOP_ORD;
                    n_ret      = S_FIN;
                    n_state    = S_PUSH_W;
                end
            end
            S_F_BUD: begin
                if (mem_rdata.order == r_ord && !mem_rdata.alloc) begin
                    n_p     = mem_rdata.prv;
                    n_n     = mem_rdata.nxt;
                    n_state = S_U_P;
                end else begin
                    n_push_idx = r_idx[PAGE_W-1:0];
                    n_push_ord = (r_ord < TOP_ORD) ? r_ord : TOP_ORD;
                    n_ret      = S_FIN;
                    n_state    = S_PUSH_W;
                end
            end
            S_U_P: begin
                if (link_ok(r_p)) begin
                    mem_req.en   = 1'b1;
                    mem_req.addr = r_p[PAGE_W-1:0];
                    n_state      = S_U_PW;
                end else begin
                    head_req.we  = 1'b1;
                    head_req.ord = r_ord;
                    head_req.val = link_ok(r_n) ? r_n : NO_LINK;
                    n_state      = S_U_N;
                end
            end
            S_U_PW: begin
                wd.nxt        = r_n;
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = r_p[PAGE_W-1:0];
                mem_req.wdata = wd;
                n_state       = S_U_N;
            end
            S_U_N: begin
                if (link_ok(r_n)) begin
                    mem_req.en   = 1'b1;
                    mem_req.addr = r_n[PAGE_W-1:0];
                    n_state      = S_U_NW;
                end else begin
                    n_state = S_F_MRG;
                end
            end
            S_U_NW: begin
                wd.prv        = link_ok(r_p) ? r_p : NO_LINK;
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = r_n[PAGE_W-1:0];
                mem_req.wdata = wd;
                n_state       = S_F_MRG;
            end
            S_F_MRG: begin
                // advance to the merged block one order up
                n_idx        = {1'b0, midx};
                n_ord        = r_ord + ORD_W'(1);
                mem_req.en   = 1'b1;
                mem_req.addr = midx;
                n_state      = S_F_MW;
            end
            S_F_MW: begin
                wd.order      = r_ord;
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = r_idx[PAGE_W-1:0];
                mem_req.wdata = wd;
                n_state       = S_F_CHK;
            end
            // ---------------- add range ----------------
            S_R_START: begin
                if (r_count == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_end   = rng_sum_end;
                    n_state = S_R_LOOP;
                end
            end
            S_R_LOOP: begin
                if (r_idx < r_end) begin
                    n_push_idx = r_idx[PAGE_W-1:0];
                    n_push_ord = rord;
                    n_idx      = r_idx + (LINK_W'(1) << rord);
                    n_ret      = S_R_LOOP;
                    n_state    = S_PUSH_W;
                end else begin
                    n_state = S_FIN;
                end
            end
            // ---------------- push onto a free list ----------------
            S_PUSH_W: begin
                n_h           = head_rd_val;
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = r_push_idx;
                mem_req.wdata = '{alloc: 1'b0, order: r_push_ord,
                                  nxt: head_rd_val, prv: NO_LINK};
                head_req.we   = 1'b1;
                head_req.ord  = r_push_ord;
                head_req.val  = {1'b0, r_push_idx};
                n_state       = link_ok(head_rd_val) ? S_PUSH_R : r_ret;
            end
            S_PUSH_R: begin
                mem_req.en   = 1'b1;
                mem_req.addr = r_h[PAGE_W-1:0];
                n_state      = S_PUSH_M;
            end
            S_PUSH_M: begin
                wd.prv        = {1'b0, r_push_idx};
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = r_h[PAGE_W-1:0];
                mem_req.wdata = wd;
                n_state       = r_ret;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_page   = r_res_page;
                    n_out_order  = r_res_order;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ret       <= S_IDLE;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_managed   <= LINK_W'(PAGE_COUNT);
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) r_managed <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size       <= n_size;
        r_idx        <= n_idx;
        r_end        <= n_end;
        r_count      <= n_count;
        r_p          <= n_p;
        r_n          <= n_n;
        r_h          <= n_h;
        r_ord        <= n_ord;
        r_tgt        <= n_tgt;
        r_j          <= n_j;
        r_push_ord   <= n_push_ord;
        r_buddy      <= n_buddy;
        r_push_idx   <= n_push_idx;
        r_res_status <= n_res_status;
        r_res_page   <= n_res_page;
        r_res_order  <= n_res_order;
        r_out_status <= n_out_status;
        r_out_page   <= n_out_page;
        r_out_order  <= n_out_order;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_block_page  = r_out_page;
    assign o_block_order = r_out_order;

    `BPA_ASSERT(a_clear_holds_input, i_clk, i_rst_n, (r_state == S_CLEAR) |-> o_in_stall)
    `BPA_ASSERT(a_fail_zero_payload, i_clk, i_rst_n, (o_out_valid && o_status) |-> (o_block_page == '0 && o_block_order == '0))
    `BPA_ASSERT(a_ok_order_range, i_clk, i_rst_n, (o_out_valid && !o_status) |-> (o_block_order < ORD_W'(ORDER_COUNT)))
    `BPA_NEVER(a_mem_quiet_idle, i_clk, i_rst_n, r_state == S_IDLE && mem_req.en)
endmodule

// ----- bench/buddy_page_allocator_core_tb.sv -----
// Testbench for the buddy page allocator core: self-checking, with a predictor of the frame table.
// Depends on bpa_pkg and the core top level buddy_page_allocator_core.
`timescale 1ns / 100ps
module buddy_page_allocator_core_tb;
    import bpa_pkg::*;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int NPAGE = PAGE_COUNT;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] size_bytes;
        logic [15:0] free_page;
        logic [15:0] range_first;
        logic [16:0] range_count;
    } t_request;

    typedef struct {
        logic        status;
        logic [15:0] page;
        logic [3:0]  order;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [31:0] i_size_bytes;
    logic [15:0] i_free_page;
    logic [15:0] i_range_first_page;
    logic [16:0] i_range_page_count;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_status;
    logic [15:0] o_block_page;
    logic [3:0]  o_block_order;
    logic        i_cfg_we;
    logic [16:0] i_cfg_wdata;

    buddy_page_allocator_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_size_bytes       (i_size_bytes),
        .i_free_page        (i_free_page),
        .i_range_first_page (i_range_first_page),
        .i_range_page_count (i_range_page_count),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_block_page       (o_block_page),
        .o_block_order      (o_block_order),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    // Shadow copy of the frame table, free list heads and the merge limit.
    logic [3:0]  shadow_order [NPAGE];
    bit          shadow_taken [NPAGE];
    logic [16:0] shadow_next  [NPAGE];
    logic [16:0] shadow_prev  [NPAGE];
    bit          link_written [NPAGE];
    logic [16:0] list_head    [ORDER_COUNT];
    int unsigned merge_limit;

    // Pages whose links were written: the only ones safe to free.
    int unsigned linked_pages[$];
    // Blocks handed out and not yet returned.
    int unsigned granted_blocks[$];

    t_request pending_requests[$];
    t_grant   expected_grants[$];

    int mismatch_count;
    int sender_idle_pct;
    int receiver_stall_pct;
    int cycle_count;

    // ---------------------------------------------------------------
    // Predictor: list and frame table operations
    // ---------------------------------------------------------------
    function automatic void list_push(int unsigned idx, int unsigned ord);
        logic [16:0] h;
        h = list_head[ord];
        shadow_order[idx] = 4'(ord);
        shadow_taken[idx] = 1'b0;
        shadow_prev[idx] = NO_LINK;
        shadow_next[idx] = h;
        if (!link_written[idx]) begin
            link_written[idx] = 1'b1;
            linked_pages.push_back(idx);
        end
        if (h < NPAGE) shadow_prev[h[15:0]] = 17'(idx);
        list_head[ord] = 17'(idx);
    endfunction

    function automatic void list_unlink(int unsigned idx, int unsigned ord);
        logic [16:0] p;
        logic [16:0] n;
        p = shadow_prev[idx];
        n = shadow_next[idx];
        if (p < NPAGE) shadow_next[p[15:0]] = n;
        else list_head[ord] = (n < NPAGE) ? n : NO_LINK;
        if (n < NPAGE) shadow_prev[n[15:0]] = (p < NPAGE) ? p : NO_LINK;
    endfunction

    function automatic int unsigned list_pop(int unsigned ord);
        logic [16:0] h;
        logic [16:0] n;
        h = list_head[ord];
        n = shadow_next[h[15:0]];
        shadow_taken[h[15:0]] = 1'b1;
        if (n < NPAGE) begin
            shadow_prev[n[15:0]] = NO_LINK;
            list_head[ord] = n;
        end else begin
            list_head[ord] = NO_LINK;
        end
        return h;
    endfunction

    function automatic t_grant predict_alloc(logic [31:0] size);
        t_grant g;
        int unsigned ord;
        int unsigned k;
        int unsigned j;
        int unsigned blk;
        int unsigned half;
        g = '{1'b0, 16'd0, 4'd0};
        ord = 0;
        while (ord < 24 && ((64'd4096 << ord) < {32'd0, size})) ord++;
        if (ord >= ORDER_COUNT) begin
            g.status = 1'b1;
            return g;
        end
        k = ord;
        while (k < ORDER_COUNT && list_head[k] >= NPAGE) k++;
        if (k >= ORDER_COUNT) begin
            g.status = 1'b1;
            return g;
        end
        blk = list_pop(k);
        // Split down, upper halves go one order lower.
        for (j = k; j > ord; j--) begin
            half = blk + (1 << (j - 1));
            if (half < NPAGE) list_push(half, j - 1);
        end
        shadow_order[blk] = 4'(ord);
        granted_blocks.push_back(blk);
        g.page = 16'(blk);
        g.order = 4'(ord);
        return g;
    endfunction

    function automatic void predict_free(int unsigned idx);
        int unsigned lim;
        int unsigned ord;
        int unsigned buddy;
        lim = (merge_limit < NPAGE) ? merge_limit : NPAGE;
        shadow_taken[idx] = 1'b0;
        ord = shadow_order[idx];
        buddy = idx ^ (1 << (ord & 15));
        while (ord + 1 < ORDER_COUNT && buddy < lim &&
               shadow_order[buddy] == 4'(ord) && !shadow_taken[buddy]) begin
            list_unlink(buddy, ord);
            idx = idx & buddy;
            ord++;
            shadow_order[idx] = 4'(ord);
            buddy = idx ^ (1 << ord);
        end
        list_push(idx, (shadow_order[idx] < ORDER_COUNT) ? shadow_order[idx] : ORDER_COUNT - 1);
    endfunction

    function automatic void predict_add(int unsigned first, int unsigned count);
        int unsigned last;
        int unsigned ord;
        if (first >= NPAGE || count == 0) return;
        last = first + count;
        if (last > NPAGE) last = NPAGE;
        while (first < last) begin
            ord = 0;
            // Page 0 counts as aligned to the top order.
            if (first == 0) ord = ORDER_COUNT - 1;
            else while (ord < ORDER_COUNT - 1 && ((first >> ord) & 1) == 0) ord++;
            while (ord > 0 && (1 << ord) > last - first) ord--;
            list_push(first, ord);
            first += 1 << ord;
        end
    endfunction

    // ---------------------------------------------------------------
    // Request builders: predict, then queue the request and its grant
    // ---------------------------------------------------------------
    function automatic t_request noise_request(logic [1:0] op);
        t_request r;
        r.op = op;
        r.size_bytes = $urandom;
        r.free_page = 16'($urandom);
        r.range_first = 16'($urandom);
        r.range_count = 17'($urandom);
        return r;
    endfunction

    function automatic void queue_alloc(logic [31:0] size);
        t_request r;
        r = noise_request(OP_ALLOC);
        r.size_bytes = size;
        pending_requests.push_back(r);
        expected_grants.push_back(predict_alloc(size));
    endfunction

    function automatic void queue_free(int unsigned page);
        t_request r;
        r = noise_request(OP_FREE);
        r.free_page = 16'(page);
        predict_free(page);
        pending_requests.push_back(r);
        expected_grants.push_back('{1'b0, 16'd0, 4'd0});
    endfunction

    function automatic void queue_add(int unsigned first, int unsigned count);
        t_request r;
        r = noise_request(OP_ADD);
        r.range_first = 16'(first);
        r.range_count = 17'(count);
        predict_add(first, count);
        pending_requests.push_back(r);
        expected_grants.push_back('{1'b0, 16'd0, 4'd0});
    endfunction

    function automatic void queue_unknown();
        pending_requests.push_back(noise_request(OP_UNKNOWN));
        expected_grants.push_back('{1'b1, 16'd0, 4'd0});
    endfunction

    // Return a granted block, or rarely any linked page (double free).
    function automatic void queue_some_free();
        int unsigned pick;
        if (granted_blocks.size() > 0 && $urandom_range(99) < 93) begin
            pick = $urandom_range(granted_blocks.size() - 1);
            queue_free(granted_blocks[pick]);
            granted_blocks.delete(pick);
        end else if (linked_pages.size() > 0) begin
            queue_free(linked_pages[$urandom_range(linked_pages.size() - 1)]);
        end else begin
            queue_unknown();
        end
    endfunction

    function automatic logic [31:0] random_size();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60) return 32'($urandom_range(16384));
        if (pick < 85) return 32'($urandom_range(1 << 22));
        if (pick < 92) return 32'($urandom_range((1 << 22) + 4096, (1 << 22) - 4096));
        return $urandom;
    endfunction

    function automatic void queue_random_request();
        int unsigned pick;
        int unsigned first;
        pick = $urandom_range(99);
        if (pick < 45) begin
            queue_alloc(random_size());
        end else if (pick < 85) begin
            queue_some_free();
        end else if (pick < 97) begin
            first = $urandom_range(NPAGE - 1);
            if ($urandom_range(9) == 0) queue_add(first, $urandom_range(NPAGE));
            else queue_add(first, $urandom_range(64));
        end else begin
            queue_unknown();
        end
    endfunction

    // ---------------------------------------------------------------
    // Clock, cycle counter and timeout
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Driver: present the oldest pending request, idle at random
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            // Slot is free: either nothing was offered or the transfer just happened.
            if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                i_in_valid <= 1'b1;
                i_operation <= pending_requests[0].op;
                i_size_bytes <= pending_requests[0].size_bytes;
                i_free_page <= pending_requests[0].free_page;
                i_range_first_page <= pending_requests[0].range_first;
                i_range_page_count <= pending_requests[0].range_count;
                void'(pending_requests.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure: redraw every cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // ---------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest grant
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_grants.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d page %0d order %0d",
                             o_status, o_block_page, o_block_order);
            end else begin
                want = expected_grants.pop_front();
                if (o_status !== want.status || o_block_page !== want.page ||
                    o_block_order !== want.order) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected status %0d page %0d order %0d, got %0d %0d %0d",
                                 want.status, want.page, want.order,
                                 o_status, o_block_page, o_block_order);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: reset, directed requests, random phases, config writes
    // ---------------------------------------------------------------
    task automatic drain_queues();
        while (pending_requests.size() > 0 || expected_grants.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_merge_limit(logic [16:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        merge_limit = value;
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) queue_random_request();
        drain_queues();
    endtask

    initial begin
        cycle_count = 0;
        mismatch_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_operation = OP_ALLOC;
        i_size_bytes = '0;
        i_free_page = '0;
        i_range_first_page = '0;
        i_range_page_count = '0;
        merge_limit = NPAGE;
        for (int i = 0; i < NPAGE; i++) begin
            shadow_order[i] = 4'd0;
            shadow_taken[i] = 1'b1;
            shadow_next[i] = '0;
            shadow_prev[i] = '0;
            link_written[i] = 1'b0;
        end
        for (int i = 0; i < ORDER_COUNT; i++) list_head[i] = NO_LINK;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty lists, unknown op, empty and clipped ranges,
        // page 0 alignment, size extremes, split and merge.
        write_merge_limit(17'd65536);
        queue_alloc(32'd4096);
        queue_unknown();
        queue_add(0, 0);
        queue_add(300, 0);
        queue_add(65000, 65536);
        queue_add(0, 65000);
        queue_alloc(32'd0);
        queue_alloc(32'd1);
        queue_alloc(32'd4096);
        queue_alloc(32'd4097);
        queue_alloc(32'd1 << 22);
        queue_alloc((32'd1 << 22) + 32'd1);
        queue_alloc(32'hFFFF_FFFF);
        queue_alloc(32'd12288);
        while (granted_blocks.size() > 0) begin
            queue_free(granted_blocks[0]);
            void'(granted_blocks.pop_front());
        end
        queue_free(65535);
        queue_alloc(32'd1 << 21);
        queue_unknown();
        drain_queues();

        // Random phases with varying merge limits, sender idling and receiver stalls.
        run_phase(0, 0, 250);
        write_merge_limit(17'd1024);
        run_phase(69, 0, 250);
        write_merge_limit(17'd0);
        run_phase(0, 69, 250);
        write_merge_limit(17'($urandom_range(NPAGE)));
        run_phase(16, 16, 150);
        write_merge_limit(17'd65535);
        run_phase(0, 0, 100);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_frame_mem.sv
hw/rtl/bpa_head_table.sv
hw/rtl/buddy_page_allocator_core.sv
bench/buddy_page_allocator_core_tb.sv
